/* src/vector3_normalize_defines.svh */
// Assertion macros shared by the vector normalisation block.
// Depends on nothing; included by the modules that assert.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

// Assert an implication on the following cycle, with reset disabling the check.
`define V3N_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("v3n check failed");

// Assert an implication in the same cycle, with reset disabling the check.
`define V3N_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("v3n check failed");

`endif

/* src/v3n_pkg.sv */
// Package for the vector normalisation block: widths and pipeline depths.
// Depends on nothing; used by v3n_pipe and vector3_normalize.
package v3n_pkg;
   localparam int CompWidth   = 32;
   localparam int SumWidth    = 64;
   localparam int RootWidth   = 32;
   localparam int UnitFrac    = 30;
   localparam int DivWidth    = 62;
   // square-root stages, one result bit each
   localparam int SqrtStages  = RootWidth;
   // division stages, one quotient bit each (quotient fits in 31 bits)
   localparam int DivStages   = 31;
   localparam int PipeDepth   = 2 + SqrtStages + DivStages + 1;
endpackage

/* src/v3n_pipe.sv */
// Pipelined datapath: squares, bit-per-stage square root, bit-per-stage divides.
// Depends on v3n_pkg and vector3_normalize_defines.svh.
`include "vector3_normalize_defines.svh"
module v3n_pipe
   import v3n_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic signed [CompWidth-1:0]  in_x,
   input  logic signed [CompWidth-1:0]  in_y,
   input  logic signed [CompWidth-1:0]  in_z,
   output logic                         out_valid,
   output logic [RootWidth-1:0]         out_len,
   output logic signed [CompWidth-1:0]  out_ux,
   output logic signed [CompWidth-1:0]  out_uy,
   output logic signed [CompWidth-1:0]  out_uz,
   output logic                         out_zero
);
   localparam int NS = 2 + SqrtStages + DivStages + 1;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;

   // stage 0: magnitudes and signs
   logic [CompWidth-1:0] m0_ff [3];
   logic [2:0]           n0_ff;
   // stage 1: squares and their sum
   logic [SumWidth-1:0]  sq1_ff [3];
   logic [CompWidth-1:0] m1_ff [3];
   logic [2:0]           n1_ff;
   logic [SumWidth-1:0]  sum_c;

   // square-root pipeline
   logic [SumWidth-1:0]  srem_ff  [SqrtStages+1];
   logic [RootWidth-1:0] sroot_ff [SqrtStages+1];
   logic [CompWidth-1:0] sm_ff    [SqrtStages+1][3];
   logic [2:0]           sn_ff    [SqrtStages+1];

   // divide pipeline: remainder, quotient per lane
   logic [RootWidth:0]   drem_ff [DivStages+1][3];
   logic [DivWidth-1:0]  dnum_ff [DivStages+1][3];
   logic [DivStages-1:0] dq_ff   [DivStages+1][3];
   logic [RootWidth-1:0] dlen_ff [DivStages+1];
   logic [2:0]           dn_ff   [DivStages+1];

   logic [RootWidth-1:0] len_ff;
   logic signed [CompWidth-1:0] u_ff [3];
   logic                 zero_ff;

   logic signed [CompWidth-1:0] comp_in [3];
   assign comp_in[0] = in_x;
   assign comp_in[1] = in_y;
   assign comp_in[2] = in_z;

   // advance valid bits with the data
   assign vld_in = {vld_ff[NS-2:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0 and 1: magnitudes, then squares
   assign sum_c = sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n0_ff[i] <= comp_in[i][CompWidth-1];
            m0_ff[i] <= comp_in[i][CompWidth-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
            sq1_ff[i] <= SumWidth'(m0_ff[i]) * SumWidth'(m0_ff[i]);
            m1_ff[i] <= m0_ff[i];
         end
         n1_ff <= n0_ff;
      end
   end

   // square root: one root bit per stage, restoring method
   always_comb begin
      srem_ff[0]  = sum_c;
      sroot_ff[0] = '0;
      sm_ff[0]    = m1_ff;
      sn_ff[0]    = n1_ff;
   end

   for (genvar s = 0; s < SqrtStages; s++) begin : g_sqrt
      localparam int B = SqrtStages - 1 - s;
      logic [SumWidth-1:0]  trial;
      logic [SumWidth-1:0]  rem_in;
      logic [RootWidth-1:0] root_in;
      always_comb begin
         trial   = ({32'd0, sroot_ff[s]} << (B + 1)) | (SumWidth'(1) << (2 * B));
         rem_in  = srem_ff[s];
         root_in = sroot_ff[s];
         if (srem_ff[s] >= trial) begin
            rem_in  = srem_ff[s] - trial;
            root_in = sroot_ff[s] | (RootWidth'(1) << B);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            srem_ff[s+1]  <= rem_in;
            sroot_ff[s+1] <= root_in;
            sm_ff[s+1]    <= sm_ff[s];
            sn_ff[s+1]    <= sn_ff[s];
         end
      end
   end

   // divide setup: the upper numerator bits (magnitude halved) are below the
   // length and seed the remainder; the lowest magnitude bit is shifted in first
   always_comb begin
      dlen_ff[0] = sroot_ff[SqrtStages];
      dn_ff[0]   = sn_ff[SqrtStages];
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] = {1'b0, sm_ff[SqrtStages][i] >> 1};
         dnum_ff[0][i] = (DivWidth'(sm_ff[SqrtStages][i]) << UnitFrac)
                         << (DivWidth - DivStages);
         dq_ff[0][i]   = '0;
      end
   end

   for (genvar s = 0; s < DivStages; s++) begin : g_div
      logic [RootWidth:0]   r_sh [3];
      logic [RootWidth:0]   r_in [3];
      logic [DivStages-1:0] q_in [3];
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            r_sh[i] = {drem_ff[s][i][RootWidth-1:0], dnum_ff[s][i][DivWidth-1]};
            r_in[i] = r_sh[i];
            q_in[i] = {dq_ff[s][i][DivStages-2:0], 1'b0};
            if (r_sh[i] >= {1'b0, dlen_ff[s]}) begin
               r_in[i] = r_sh[i] - {1'b0, dlen_ff[s]};
               q_in[i][0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               drem_ff[s+1][i] <= r_in[i];
               dnum_ff[s+1][i] <= dnum_ff[s][i] << 1;
               dq_ff[s+1][i]   <= q_in[i];
            end
            dlen_ff[s+1] <= dlen_ff[s];
            dn_ff[s+1]   <= dn_ff[s];
         end
      end
   end

   // output stage: sign, zero vector
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= (dlen_ff[DivStages] == '0);
         len_ff  <= dlen_ff[DivStages];
         for (int i = 0; i < 3; i++) begin
            if (dlen_ff[DivStages] == '0) begin
               u_ff[i] <= '0;
            end else if (dn_ff[DivStages][i]) begin
               u_ff[i] <= -$signed({1'b0, dq_ff[DivStages][i]});
            end else begin
               u_ff[i] <= $signed({1'b0, dq_ff[DivStages][i]});
            end
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_len   = len_ff;
   assign out_ux    = u_ff[0];
   assign out_uy    = u_ff[1];
   assign out_uz    = u_ff[2];
   assign out_zero  = zero_ff;

   `V3N_ASSERT_SAME(a_zero_len, clock, reset, out_valid && out_zero, out_len == '0)
   `V3N_ASSERT_SAME(a_zero_unit, clock, reset, out_valid && out_zero,
      out_ux == '0 && out_uy == '0 && out_uz == '0)
   `V3N_ASSERT_NEXT(a_hold, clock, reset, !adv, $stable(vld_ff))
endmodule

/* src/vector3_normalize.sv */
// Vector normalisation block: length and unit vector of a Q16.16 3D vector.
// An item is accepted every cycle unless stalled; there are 2 square stages,
// 32 square-root stages, one per root bit, 31 divide stages, one per quotient
// bit, and an output stage. The whole pipeline stalls while the result waits.
// Depends on v3n_pkg, v3n_pipe and vector3_normalize_defines.svh.
`include "vector3_normalize_defines.svh"
module vector3_normalize
   import v3n_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // vec_x [31:0], vec_y [63:32], vec_z [95:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // length, unit_x, unit_y, unit_z
   output logic         rsp_tuser   // zero_length
);
   logic adv;
   logic out_valid;
   logic [RootWidth-1:0] len;
   logic signed [CompWidth-1:0] ux, uy, uz;
   logic zero;

   // advance when the result slot is empty or being taken
   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv;

   v3n_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_x      (req_tdata[31:0]),
      .in_y      (req_tdata[63:32]),
      .in_z      (req_tdata[95:64]),
      .out_valid (out_valid),
      .out_len   (len),
      .out_ux    (ux),
      .out_uy    (uy),
      .out_uz    (uz),
      .out_zero  (zero)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {uz, uy, ux, len};
   assign rsp_tuser  = zero;

   `V3N_ASSERT_NEXT(a_stall, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `V3N_ASSERT_NEXT(a_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `V3N_ASSERT_SAME(a_ready, clock, reset, !rsp_tvalid, req_tready)
endmodule

/* tb/testbench.sv */
// Self-checking bench for vector3_normalize: random and directed 3D vectors,
// predicted length and unit vector compared field by field. Depends on v3n_pkg.
module testbench;
   import v3n_pkg::*;

   localparam int Latency = PipeDepth + 4;
   localparam longint CycleLimit = 400000;

   typedef struct packed {
      logic        zero_len;
      logic [31:0] unit_z;
      logic [31:0] unit_y;
      logic [31:0] unit_x;
      logic [31:0] len;
   } norm_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;  // vec_x [31:0], vec_y [63:32], vec_z [95:64]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;  // length, unit_x, unit_y, unit_z
   logic         rsp_tuser;  // zero_length

   logic [95:0] pending_vecs[$];
   norm_t       expected_norms[$];
   int          failures = 0;
   bit          req_taken = 0;
   bit          hold_sender = 0;
   bit          calm = 0;
   longint      cycles = 0;
   int          send_gap = 0;
   int          recv_gap = 0;

   vector3_normalize DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Integer square root of a 64-bit sum, truncated.
   function automatic logic [31:0] int_root(logic [63:0] v);
      logic [63:0] rem, root, bitv;
      rem = v; root = 0; bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   function automatic logic [31:0] unit_comp(logic [31:0] c, logic [31:0] len);
      logic [63:0] mag, q;
      mag = c[31] ? {32'd0, -c} : {32'd0, c};
      q = (mag << UnitFrac) / {32'd0, len};
      if (c[31]) q = -q;
      return q[31:0];
   endfunction

   function automatic norm_t normalise(logic [95:0] v);
      norm_t r;
      logic [63:0] mx, my, mz, sum;
      mx = v[31] ? {32'd0, -v[31:0]} : {32'd0, v[31:0]};
      my = v[63] ? {32'd0, -v[63:32]} : {32'd0, v[63:32]};
      mz = v[95] ? {32'd0, -v[95:64]} : {32'd0, v[95:64]};
      sum = mx * mx + my * my + mz * mz;
      r = '0;
      if (sum == 0) begin
         r.zero_len = 1'b1;
      end else begin
         r.len = int_root(sum);
         r.unit_x = unit_comp(v[31:0], r.len);
         r.unit_y = unit_comp(v[63:32], r.len);
         r.unit_z = unit_comp(v[95:64], r.len);
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 255) - 128;
         2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         4: return 32'd0;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // Drive items and response ready at the falling edge, each with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0 || hold_sender || pending_vecs.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_vecs.pop_front();
            if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_tready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 15);
      end
   end

   // Predict on acceptance, check results at the rising edge.
   always @(posedge clock) begin
      norm_t got, want;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_tvalid && req_tready) expected_norms.push_back(normalise(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_norms.size() == 0) begin
               $display("%0t unexpected result %h", $time, got);
               failures++;
            end else begin
               want = expected_norms.pop_front();
               if (got.len !== want.len) begin
                  $display("%0t length exp %h got %h", $time, want.len, got.len);
                  failures++;
               end
               if (got.unit_x !== want.unit_x) begin
                  $display("%0t unit_x exp %h got %h", $time, want.unit_x, got.unit_x);
                  failures++;
               end
               if (got.unit_y !== want.unit_y) begin
                  $display("%0t unit_y exp %h got %h", $time, want.unit_y, got.unit_y);
                  failures++;
               end
               if (got.unit_z !== want.unit_z) begin
                  $display("%0t unit_z exp %h got %h", $time, want.unit_z, got.unit_z);
                  failures++;
               end
               if (got.zero_len !== want.zero_len) begin
                  $display("%0t zero_length exp %b got %b", $time, want.zero_len,
                           got.zero_len);
                  failures++;
               end
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Fill the item queue, pace the run and judge the end.
   initial begin
      logic [31:0] ex[$];
      req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      // directed: zero vector, extremes, single axes, mixed signs
      ex = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'h0001_0000};
      pending_vecs.push_back(96'd0);
      foreach (ex[i]) begin
         pending_vecs.push_back({32'd0, 32'd0, ex[i]});
         pending_vecs.push_back({32'd0, ex[i], 32'd0});
         pending_vecs.push_back({ex[i], 32'd0, 32'd0});
      end
      pending_vecs.push_back({3{32'h8000_0000}});
      pending_vecs.push_back({3{32'h7fff_ffff}});
      pending_vecs.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
      pending_vecs.push_back({3{32'hffff_ffff}});
      // pause the sender until the pipeline has drained
      wait (pending_vecs.size() == 0);
      hold_sender = 1;
      repeat (10) for (int i = 0; i < 165; i++)
         pending_vecs.push_back({rand_comp(), rand_comp(), rand_comp()});
      wait (expected_norms.size() == 0 && !req_tvalid);
      hold_sender = 0;
      wait (pending_vecs.size() < 300);
      calm = 1;
      wait (pending_vecs.size() == 0 && !req_tvalid);
      wait (expected_norms.size() == 0);
      repeat (Latency) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
